// ===== src/mnc_pkg.sv =====
// Shared types, constants and helpers for the neighbor count block.
`default_nettype none

package mnc_pkg;

  localparam int MaxCols   = 256;
  localparam int AddrW     = $clog2(MaxCols);
  localparam int RowW      = 8;
  localparam int ColW      = 8;
  localparam int RowCntW   = RowW + 1;
  localparam int CountW    = 4;
  localparam int CfgW      = 9;
  localparam int WinW      = 9;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoLvlW  = FifoPtrW + 1;

  localparam logic CfgGridRows = 1'b0;
  localparam logic CfgGridCols = 1'b1;

  localparam logic [RowW-1:0] RowsM1Reset = RowW'(29);
  localparam logic [ColW-1:0] ColsM1Reset = ColW'(29);

  localparam logic KindCell  = 1'b0;
  localparam logic KindDrain = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             alive;
    logic             emit;
    logic [WinW-1:0]  keep;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last;
  } stage_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic              last;
  } result_t;

  // Size register to last index: zero acts as one, above the maximum clamps.
  function automatic logic [RowW-1:0] size_to_max_idx(input logic [CfgW-1:0] value);
    logic [RowW-1:0] idx;
    if (value == '0) begin
      idx = '0;
    end else if (value[CfgW-1]) begin
      idx = '1;
    end else begin
      idx = value[RowW-1:0] - RowW'(1);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== src/mnc_line_ram.sv =====
// Line store: one read and one write port, registered read, write forwarding.
`default_nettype none

module mnc_line_ram
  import mnc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [1:0]       wr_data_i,
  output logic [1:0]            rd_data_o
);

  logic [1:0] mem_q [MaxCols];
  logic [1:0] rd_data_q;
  logic [1:0] fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_data_q;

endmodule

`default_nettype wire

// ===== src/mnc_ctrl.sv =====
// Raster position counters, frame tracking and edge masks per request.
`default_nettype none

module mnc_ctrl
  import mnc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_index_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic            accept_i,
  input  wire logic            kind_i,
  input  wire logic            cell_i,
  output logic                 issue_o,
  output stage_t               stage_o
);

  localparam logic [WinW-1:0] KeepAll   = 9'h1EF;
  localparam logic [WinW-1:0] MaskLeft  = 9'h007;
  localparam logic [WinW-1:0] MaskRight = 9'h1C0;
  localparam logic [WinW-1:0] MaskTop   = 9'h049;
  localparam logic [WinW-1:0] MaskBot   = 9'h124;

  logic [RowW-1:0]    rows_m1_q, rows_m1_d;
  logic [ColW-1:0]    cols_m1_q, cols_m1_d;
  logic [RowCntW-1:0] in_row_q, in_row_d;
  logic [ColW-1:0]    in_col_q, in_col_d;
  logic [RowW-1:0]    out_row_q, out_row_d;
  logic [ColW-1:0]    out_col_q, out_col_d;
  logic               frame_done_q, frame_done_d;
  logic               active;
  logic               emit;
  logic               last;
  logic [RowCntW-1:0] in_row_inc;
  logic [WinW-1:0]    keep;

  assign active  = !(kind_i == KindDrain && !frame_done_q);
  assign issue_o = accept_i && active;
  assign emit    = (in_row_q >= RowCntW'(2)) || (in_row_q == RowCntW'(1) && in_col_q != '0);
  assign last    = (out_row_q == rows_m1_q) && (out_col_q == cols_m1_q);

  always_comb begin
    keep = KeepAll;
    if (out_col_q == '0) begin
      keep = keep & ~MaskLeft;
    end
    if (out_col_q == cols_m1_q) begin
      keep = keep & ~MaskRight;
    end
    if (out_row_q == '0) begin
      keep = keep & ~MaskTop;
    end
    if (out_row_q == rows_m1_q) begin
      keep = keep & ~MaskBot;
    end
  end

  assign stage_o.addr  = in_col_q;
  assign stage_o.alive = frame_done_q ? 1'b0 : cell_i;
  assign stage_o.emit  = emit;
  assign stage_o.keep  = keep;
  assign stage_o.row   = out_row_q;
  assign stage_o.col   = out_col_q;
  assign stage_o.last  = emit && last;

  always_comb begin
    rows_m1_d    = rows_m1_q;
    cols_m1_d    = cols_m1_q;
    in_row_d     = in_row_q;
    in_col_d     = in_col_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    frame_done_d = frame_done_q;
    in_row_inc   = in_row_q + RowCntW'(1);
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgGridRows: rows_m1_d = size_to_max_idx(cfg_data_i);
        CfgGridCols: cols_m1_d = ColW'(size_to_max_idx(cfg_data_i));
        default: ;
      endcase
      in_row_d     = '0;
      in_col_d     = '0;
      out_row_d    = '0;
      out_col_d    = '0;
      frame_done_d = 1'b0;
    end else if (issue_o) begin
      if (in_col_q == cols_m1_q) begin
        in_col_d = '0;
        in_row_d = in_row_inc;
        if (in_row_inc > {1'b0, rows_m1_q}) begin
          frame_done_d = 1'b1;
        end
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (emit) begin
        if (last) begin
          in_row_d     = '0;
          in_col_d     = '0;
          out_row_d    = '0;
          out_col_d    = '0;
          frame_done_d = 1'b0;
        end else if (out_col_q == cols_m1_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m1_q    <= RowsM1Reset;
      cols_m1_q    <= ColsM1Reset;
      in_row_q     <= '0;
      in_col_q     <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      frame_done_q <= 1'b0;
    end else begin
      rows_m1_q    <= rows_m1_d;
      cols_m1_q    <= cols_m1_d;
      in_row_q     <= in_row_d;
      in_col_q     <= in_col_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
      frame_done_q <= frame_done_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/mnc_out_fifo.sv =====
// Small result queue between the window stage and the output channel.
`default_nettype none

module mnc_out_fifo
  import mnc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire result_t  push_data_i,
  input  wire logic     pop_i,
  output logic          valid_o,
  output result_t       head_o,
  output logic [FifoLvlW-1:0] level_o
);

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoLvlW-1:0] level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      level_q <= level_q + FifoLvlW'(push_i) - FifoLvlW'(pop_i);
    end
  end

  assign valid_o = (level_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

// ===== src/moore_neighbor_count.sv =====
// Top level: streaming 3x3 live-neighbor counter over a raster cell grid.
//
// Cells enter in row-major order at one request per clock while in_stall_o is
// low; each result leaves the grid position of its cell together with the count
// of live cells among its eight neighbors, delayed by one row plus one cell of
// requests and then registered by the line store read and the result queue. The
// line store is a single memory of one entry per column with one read and one
// write port; its read-modify-write each request sets the rate of one cell per
// cycle, and a write to the column being read in the same cycle is forwarded.
// No clearing pass follows reset: cells outside the grid are masked, so the
// store's old contents never reach a count. After a frame's last cell, drain
// requests push out the remaining results; a drain request outside that phase
// is taken and dropped. A four-entry result queue lets requests keep flowing
// while results wait. Writing grid_rows or grid_cols restarts the frame and is
// allowed only while the block is idle: a rule for the user, not enforced.
`default_nettype none

module moore_neighbor_count
  import mnc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            kind_i,
  input  wire logic            cell_req_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [CountW-1:0]    count_o,
  output logic [RowW-1:0]      row_o,
  output logic [ColW-1:0]      col_o,
  output logic                 last_o
);

  logic                cfg_we;
  logic                accept;
  logic                issue;
  stage_t              stage;
  stage_t              s1_q;
  logic                s1_valid_q;
  logic [WinW-1:0]     window_q, window_d;
  logic [1:0]          entry;
  logic [2:0]          column;
  logic [WinW-1:0]     live;
  logic [CountW-1:0]   count;
  logic                push;
  result_t             push_data;
  result_t             head;
  logic                pop;
  logic [FifoLvlW-1:0] level;
  logic [FifoLvlW:0]   pending;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign pending    = {1'b0, level} + (FifoLvlW+1)'(s1_valid_q && s1_q.emit);
  assign in_stall_o = (pending >= (FifoLvlW+1)'(FifoDepth));
  assign accept     = in_valid_i && !in_stall_o;

  mnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .cell_i      (cell_req_i),
    .issue_o     (issue),
    .stage_o     (stage)
  );

  mnc_line_ram u_line_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (issue),
    .rd_addr_i (stage.addr),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_q.addr),
    .wr_data_i ({entry[0], s1_q.alive}),
    .rd_data_o (entry)
  );

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= stage;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      window_q   <= '0;
    end else begin
      s1_valid_q <= issue;
      window_q   <= window_d;
    end
  end

  assign column = {s1_q.alive, entry[0], entry[1]};
  assign live   = {column, window_q[WinW-1:3]} & s1_q.keep;

  always_comb begin
    window_d = window_q;
    if (cfg_we) begin
      window_d = '0;
    end else if (s1_valid_q) begin
      window_d = s1_q.last ? '0 : {column, window_q[WinW-1:3]};
    end
  end

  always_comb begin
    count = '0;
    for (int k = 0; k < WinW; k++) begin
      count = count + CountW'(live[k]);
    end
  end

  assign push            = s1_valid_q && s1_q.emit;
  assign push_data.count = count;
  assign push_data.row   = s1_q.row;
  assign push_data.col   = s1_q.col;
  assign push_data.last  = s1_q.last;
  assign pop             = out_valid_o && !out_stall_i;

  mnc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .head_o      (head),
    .level_o     (level)
  );

  assign count_o = head.count;
  assign row_o   = head.row;
  assign col_o   = head.col;
  assign last_o  = head.last;

endmodule

`default_nettype wire

// ===== verif/moore_neighbor_count_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the streaming 3x3 live-neighbor counter.
module moore_neighbor_count_test;
  import mnc_pkg::*;

  localparam int unsigned MaxRows       = 256;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PhaseReqs     = 250;
  localparam int unsigned IdleMix [4]   = '{0, 58, 0, 38};
  localparam int unsigned StallMix [4]  = '{0, 0, 58, 38};

  typedef enum logic {StepItem, StepCfg} step_e;
  typedef enum logic [1:0] {ExpModel, ExpNone, ExpGiven} exp_e;

  typedef struct packed {
    step_e           op;
    logic            idx;
    logic [CfgW-1:0] data;
    logic            kind;
    logic            alive;
    exp_e            how;
    result_t         res;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 1'b0;
  logic [CfgW-1:0]   cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              kind_i      = 1'b0;
  logic              cell_req_i  = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [CountW-1:0] count_o;
  logic [RowW-1:0]   row_o;
  logic [ColW-1:0]   col_o;
  logic              last_o;

  moore_neighbor_count uut (.*);

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // neighbor-count predictor state
  logic [1:0]      line_bits [MaxCols] = '{default: '0};
  logic [WinW-1:0] win_bits   = '0;
  logic [CfgW-1:0] rows_reg   = 9'd30;
  logic [CfgW-1:0] cols_reg   = 9'd30;
  int unsigned     in_r       = 0;
  int unsigned     in_c       = 0;
  int unsigned     out_r      = 0;
  int unsigned     out_c      = 0;
  bit              frame_full = 1'b0;

  result_t     pending_counts [$];
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  int unsigned mismatches     = 0;
  int unsigned counts_checked = 0;
  int unsigned reqs_taken     = 0;
  int unsigned frames_fed     = 0;
  int unsigned quiet_cycles   = 0;

  dir_row_t dir_tab [30] = '{
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b0, ExpNone,  '0},
    '{StepCfg,  CfgGridRows, 9'd0,   KindCell,  1'b0, ExpNone,  '0},
    '{StepCfg,  CfgGridCols, 9'd1,   KindCell,  1'b0, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b0, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b1, ExpGiven, '{4'd0, 8'd0, 8'd0, 1'b1}},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b0, ExpNone,  '0},
    '{StepCfg,  CfgGridRows, 9'd3,   KindCell,  1'b0, ExpNone,  '0},
    '{StepCfg,  CfgGridCols, 9'd3,   KindCell,  1'b0, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpGiven, '{4'd3, 8'd0, 8'd0, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpGiven, '{4'd5, 8'd0, 8'd1, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpGiven, '{4'd3, 8'd0, 8'd2, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpGiven, '{4'd5, 8'd1, 8'd0, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpGiven, '{4'd8, 8'd1, 8'd1, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b0, ExpGiven, '{4'd5, 8'd1, 8'd2, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpGiven, '{4'd3, 8'd2, 8'd0, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b1, ExpGiven, '{4'd5, 8'd2, 8'd1, 1'b0}},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b0, ExpGiven, '{4'd3, 8'd2, 8'd2, 1'b1}},
    '{StepCfg,  CfgGridRows, 9'd1,   KindCell,  1'b0, ExpNone,  '0},
    '{StepCfg,  CfgGridCols, 9'd2,   KindCell,  1'b0, ExpNone,  '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpModel, '0},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b1, ExpModel, '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b0, ExpModel, '0},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b0, ExpModel, '0},
    '{StepItem, CfgGridRows, 9'd0,   KindCell,  1'b1, ExpModel, '0},
    '{StepItem, CfgGridRows, 9'd0,   KindDrain, 1'b1, ExpModel, '0}
  };

  function automatic int unsigned clamp_size(input logic [CfgW-1:0] value,
                                             input int unsigned top);
    if (value == '0) return 1;
    if (value > top) return top;
    return 32'(value);
  endfunction

  function automatic void rewind_frame();
    win_bits   = '0;
    in_r       = 0;
    in_c       = 0;
    out_r      = 0;
    out_c      = 0;
    frame_full = 1'b0;
  endfunction

  function automatic bit predict_req(input logic k, input logic c,
                                     output result_t res, output bit taken);
    int unsigned     nr;
    int unsigned     nc;
    logic [1:0]      ent;
    logic [2:0]      col_bits;
    logic [WinW-1:0] keep;
    logic            v;
    bit              emit;
    nr    = clamp_size(rows_reg, MaxRows);
    nc    = clamp_size(cols_reg, MaxCols);
    res   = '0;
    taken = frame_full || k != KindDrain;
    if (!taken) return 1'b0;
    v = frame_full ? 1'b0 : c;
    ent = line_bits[in_c];
    col_bits = {v, ent[0], ent[1]};
    line_bits[in_c] = {ent[0], v};
    win_bits = {col_bits, win_bits[WinW-1:3]};
    emit = (in_r >= 2) || (in_r == 1 && in_c >= 1);
    in_c++;
    if (in_c >= nc) begin
      in_c = 0;
      in_r++;
    end
    if (in_r >= nr) frame_full = 1'b1;
    if (!emit) return 1'b0;
    // drop the center and every window cell outside the grid
    keep = 9'h1EF;
    if (out_c == 0) keep &= ~9'h007;
    if (out_c + 1 >= nc) keep &= ~9'h1C0;
    if (out_r == 0) keep &= ~9'h049;
    if (out_r + 1 >= nr) keep &= ~9'h124;
    res.count = CountW'($countones(win_bits & keep));
    res.row   = RowW'(out_r);
    res.col   = ColW'(out_c);
    res.last  = (out_r + 1 >= nr) && (out_c + 1 >= nc);
    if (res.last) begin
      rewind_frame();
    end else begin
      out_c++;
      if (out_c >= nc) begin
        out_c = 0;
        out_r++;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_req(input logic k, input logic c, input exp_e how,
                          input result_t given);
    result_t got;
    bit      has;
    bit      taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    cell_req_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    has = predict_req(k, c, got, taken);
    if (taken) reqs_taken++;
    case (how)
      ExpModel: if (has) pending_counts.push_back(got);
      ExpGiven: pending_counts.push_back(given);
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgGridRows) rows_reg = value;
    else cols_reg = value;
    rewind_frame();
  endtask

  task automatic feed_frame(input logic [CfgW-1:0] rows_v, input logic [CfgW-1:0] cols_v);
    int unsigned nr;
    int unsigned nc;
    int unsigned cells;
    int unsigned stop;
    int unsigned density;
    write_reg(CfgGridRows, rows_v);
    write_reg(CfgGridCols, cols_v);
    nr      = clamp_size(rows_v, MaxRows);
    nc      = clamp_size(cols_v, MaxCols);
    cells   = nr * nc;
    stop    = cells + nc + 1;
    density = $urandom_range(100);
    // cut some frames short to exercise the restart on a register write
    if ($urandom_range(9) == 0) stop = $urandom_range(1, stop - 1);
    for (int i = 0; i < stop; i++) begin
      if (i < cells && $urandom_range(24) == 0) begin
        send_req(KindDrain, 1'($urandom_range(1)), ExpModel, '0);
      end
      if (i < cells) begin
        send_req(KindCell, $urandom_range(99) < density, ExpModel, '0);
      end else begin
        send_req($urandom_range(3) == 0 ? KindCell : KindDrain, 1'($urandom_range(1)),
                 ExpModel, '0);
      end
    end
    if ($urandom_range(4) == 0) send_req(KindDrain, 1'($urandom_range(1)), ExpModel, '0);
    frames_fed++;
  endtask

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin : check_counts
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      counts_checked++;
      if (pending_counts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected count=%0d row=%0d col=%0d last=%0d", $time,
                 count_o, row_o, col_o, last_o);
      end else begin
        want = pending_counts.pop_front();
        if (count_o !== want.count || row_o !== want.row || col_o !== want.col ||
            last_o !== want.last) begin
          mismatches++;
          $display("%0t: expected count=%0d row=%0d col=%0d last=%0d,", $time,
                   want.count, want.row, want.col, want.last);
          $display("  got count=%0d row=%0d col=%0d last=%0d",
                   count_o, row_o, col_o, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("moore_neighbor_count regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == StepCfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_req(dir_tab[i].kind, dir_tab[i].alive, dir_tab[i].how, dir_tab[i].res);
    end
    for (int p = 0; p < 4; p++) begin
      idle_pct    = IdleMix[p];
      stall_pct   = StallMix[p];
      phase_start = reqs_taken;
      if (p == 1) feed_frame(9'd1, 9'd511);
      if (p == 3) feed_frame(9'd300, 9'd0);
      while (reqs_taken - phase_start < PhaseReqs) begin
        feed_frame(CfgW'($urandom_range(0, 7)),
                   CfgW'($urandom_range(9) == 0 ? $urandom_range(10, 40)
                                                : $urandom_range(0, 9)));
      end
    end
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d requests in %0d random frames plus the directed table,",
             reqs_taken, frames_fed);
    $display("%0d neighbor counts checked over four idle/stall mixes, %0d mismatches",
             counts_checked, mismatches);
    if (mismatches == 0) begin
      $display("moore_neighbor_count regression: pass");
    end else begin
      $display("moore_neighbor_count regression: fail");
    end
    $finish;
  end

endmodule
